FILE: rtl/bfdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bus frame device discovery package
// Shared types, frame constants and codes for the discovery block.
// ----------------------------------------------------------------------------
package bfdd_pkg;

    // Number of leading chunk bytes that are kept for parsing
    localparam int KEPT = 12;

    // Frame recognition bytes
    localparam logic [7:0] SOF_SHORT  = 8'h07;
    localparam logic [7:0] SOF_EXT    = 8'h0B;
    localparam logic [7:0] ADDR_MARK  = 8'hA8;
    localparam logic [7:0] EXT_MARK   = 8'hEC;
    localparam logic [7:0] DEV_SPLIT  = 8'hB0;
    localparam logic [7:0] NO_BUS_ID  = 8'hFF;
    localparam logic [7:0] NO_REQ     = 8'hFF;

    // Request and destination codes
    localparam logic [7:0] REQ_THERM  = 8'h30;
    localparam logic [7:0] REQ_CMD    = 8'h12;
    localparam logic [7:0] DEST_THERM = 8'hB4;
    localparam logic [7:0] DEST_EXCL  = 8'hB1;

    // Command codes
    localparam logic [7:0] CMD_BLIND_UP   = 8'h08;
    localparam logic [7:0] CMD_BLIND_DN   = 8'h09;
    localparam logic [7:0] CMD_BLIND_STOP = 8'h0A;
    localparam logic [7:0] CMD_SW_ON      = 8'h00;
    localparam logic [7:0] CMD_SW_OFF     = 8'h01;
    localparam logic [7:0] CMD_ALARM_A    = 8'h43;
    localparam logic [7:0] CMD_ALARM_B    = 8'h44;
    localparam logic [7:0] CMD_ALARM_C    = 8'h49;
    localparam logic [7:0] CMD_ALARM_D    = 8'h4E;
    localparam logic [7:0] CMD_DIM_A      = 8'h03;
    localparam logic [7:0] CMD_DIM_B      = 8'h04;
    localparam logic [3:0] CMD_DIM_LOW    = 4'hD;

    // Highest bus id kept as is; larger ids fold to zero
    localparam logic [7:0] MAX_BUS_ID = 8'd10;

    // Device type codes
    localparam logic [3:0] DT_NONE   = 4'd0;
    localparam logic [3:0] DT_SWITCH = 4'd1;
    localparam logic [3:0] DT_DIMMER = 4'd3;
    localparam logic [3:0] DT_BLIND  = 4'd8;
    localparam logic [3:0] DT_ALARM  = 4'd14;
    localparam logic [3:0] DT_THERM  = 4'd15;

    // Event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_NEW     = 2'd1;
    localparam logic [1:0] EV_CHANGED = 2'd2;
    localparam logic [1:0] EV_INCONS  = 2'd3;

    // Extended mode codes
    localparam logic [1:0] MODE_SHORT = 2'd0;
    localparam logic [1:0] MODE_SEEN  = 2'd1;
    localparam logic [1:0] MODE_CONF  = 2'd2;

    // Result word layout
    localparam int OUT_W = 24;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE
    } bfdd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic lookup;
        logic commit;
    } bfdd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic close;
        logic clr_last;
        logic out_free;
    } bfdd_sts_t;

endpackage : bfdd_pkg
`default_nettype wire

FILE: rtl/bfdd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfdd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : bfdd_ram
`default_nettype wire

FILE: rtl/bfdd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Discovery controller
// Sequences the table clear pass, byte intake, lookup and commit.
// ----------------------------------------------------------------------------
module bfdd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire bfdd_pkg::bfdd_sts_t sts,
    output bfdd_pkg::bfdd_cmd_t      cmd
);
    import bfdd_pkg::*;

    bfdd_state_t state_reg;
    bfdd_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && sts.close)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule : bfdd_ctrl
`default_nettype wire

FILE: rtl/bfdd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Discovery datapath
// Chunk capture, frame parse, type table access and result register.
// ----------------------------------------------------------------------------
module bfdd_dp #(
    parameter int MAX_CHUNK   = 250,
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bfdd_pkg::bfdd_cmd_t  cmd,
    output bfdd_pkg::bfdd_sts_t       sts,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 rx_last,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [bfdd_pkg::OUT_W-1:0] m_tdata
);
    import bfdd_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [7:0]       own_bus_id_reg;
    logic [7:0]       bytes_reg [KEPT];
    logic [7:0]       count_reg;
    logic [8:0]       count_inc;
    logic [1:0]       mode_reg;
    logic [AW-1:0]    clr_addr_reg;

    // Parse results
    logic             short_hit;
    logic             ext_hit;
    logic [7:0]       p_bid;
    logic [7:0]       p_dest;
    logic [7:0]       p_req;
    logic [7:0]       p_cmd;
    logic [7:0]       p_dev;
    logic [7:0]       p_dev_out;
    logic [3:0]       p_bid_c;
    logic [3:0]       p_dtype;
    logic [1:0]       p_mode;
    logic             p_hit;
    logic [11:0]      p_idx;

    logic             hit_reg;
    logic [3:0]       bid_reg;
    logic [7:0]       dev_reg;
    logic [3:0]       dtype_reg;
    logic [1:0]       mode_mid_reg;
    logic [AW-1:0]    idx_reg;

    // Decide stage
    logic [3:0]       old_type;
    logic [1:0]       ev;
    logic [1:0]       mode_fin;

    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    logic [3:0]       tbl_wdata;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_bus_id_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            own_bus_id_reg <= cfg_wr_data;
        end
    end

    // Chunk byte count; closes on the mark or at the size limit
    assign count_inc = {1'b0, count_reg} + 9'd1;
    assign sts.close = rx_last || (count_inc >= 9'(MAX_CHUNK));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.lookup)
        begin
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            count_reg <= count_inc[7:0];
        end
    end

    // Keep the leading bytes of the chunk
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (count_reg < 8'(KEPT)))
        begin
            bytes_reg[count_reg[3:0]] <= rx_byte;
        end
    end

    // Clear pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_addr_reg == AW'(TABLE_DEPTH - 1));

    // Recognize the frame and extract its fields
    always_comb
    begin
        short_hit = (count_reg > 8'd6) && (bytes_reg[0] == SOF_SHORT)
                    && (bytes_reg[1] == ADDR_MARK);
        ext_hit   = !short_hit && (count_reg > 8'd10) && (bytes_reg[0] == SOF_EXT)
                    && (bytes_reg[1] == ADDR_MARK) && (bytes_reg[2] == EXT_MARK);
        p_bid     = '0;
        p_dest    = '0;
        p_req     = NO_REQ;
        p_cmd     = '0;
        p_dev     = '0;
        p_mode    = mode_reg;
        if (short_hit)
        begin
            p_bid  = own_bus_id_reg;
            p_dest = bytes_reg[2];
            p_req  = bytes_reg[4];
            p_cmd  = bytes_reg[5];
            p_dev  = (bytes_reg[2] < DEV_SPLIT) ? bytes_reg[2] : bytes_reg[3];
            if (mode_reg == MODE_SEEN)
            begin
                p_mode = MODE_SHORT;
            end
        end
        else if (ext_hit)
        begin
            p_dest = bytes_reg[6];
            p_bid  = (bytes_reg[3] == NO_BUS_ID) ? bytes_reg[4] : bytes_reg[3];
            p_req  = bytes_reg[8];
            p_cmd  = bytes_reg[9];
            p_dev  = (bytes_reg[6] < DEV_SPLIT) ? bytes_reg[6] : bytes_reg[7];
            if (mode_reg == MODE_SHORT)
            begin
                p_mode = MODE_SEEN;
            end
        end

        p_hit     = (short_hit || ext_hit) && (p_req != NO_REQ);
        p_bid_c   = (p_bid > MAX_BUS_ID) ? 4'd0 : p_bid[3:0];
        p_idx     = {p_bid_c, p_dev};
        p_dtype   = DT_NONE;
        p_dev_out = p_dev;

        // Classify the device
        if (p_hit)
        begin
            if ((p_req == REQ_THERM) && (p_dest == DEST_THERM))
            begin
                p_dtype   = DT_THERM;
                p_dev_out = bytes_reg[3];
            end
            else if ((p_req == REQ_CMD) && (p_dest != DEST_EXCL))
            begin
                if (p_mode == MODE_SEEN)
                begin
                    p_mode = MODE_CONF;
                end
                if ((p_cmd == CMD_BLIND_UP) || (p_cmd == CMD_BLIND_DN)
                    || (p_cmd == CMD_BLIND_STOP))
                begin
                    p_dtype = DT_BLIND;
                end
                else if ((p_cmd == CMD_SW_ON) || (p_cmd == CMD_SW_OFF))
                begin
                    p_dtype = DT_SWITCH;
                end
                else if (((p_cmd == CMD_ALARM_A) || (p_cmd == CMD_ALARM_B)
                          || (p_cmd == CMD_ALARM_C) || (p_cmd == CMD_ALARM_D))
                         && (bytes_reg[2] == DEST_THERM))
                begin
                    p_dtype   = DT_ALARM;
                    p_dev_out = bytes_reg[3];
                end
                else if ((p_cmd == CMD_DIM_A) || (p_cmd == CMD_DIM_B)
                         || (p_cmd[3:0] == CMD_DIM_LOW))
                begin
                    p_dtype = DT_DIMMER;
                end
            end
        end
    end

    // Hold the parse results for the decide cycle
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg      <= p_hit;
            bid_reg      <= p_hit ? p_bid_c : 4'd0;
            dev_reg      <= p_hit ? p_dev_out : 8'd0;
            dtype_reg    <= p_dtype;
            mode_mid_reg <= p_mode;
            idx_reg      <= AW'(p_idx);
        end
    end

    // Compare with the known type
    always_comb
    begin
        ev       = EV_NONE;
        mode_fin = mode_mid_reg;
        if (hit_reg && (dtype_reg != DT_NONE))
        begin
            if (old_type == DT_NONE)
            begin
                ev = EV_NEW;
                if (mode_mid_reg == MODE_SEEN)
                begin
                    mode_fin = MODE_CONF;
                end
            end
            else if ((old_type == DT_SWITCH) && (dtype_reg == DT_DIMMER))
            begin
                ev = EV_CHANGED;
            end
            else if (old_type != dtype_reg)
            begin
                ev = EV_INCONS;
            end
        end
    end

    // Table write: clear pass or update on commit
    assign tbl_we    = cmd.clr_wr || (cmd.commit && (ev != EV_NONE));
    assign tbl_waddr = cmd.clr_wr ? clr_addr_reg : idx_reg;
    assign tbl_wdata = cmd.clr_wr ? DT_NONE : dtype_reg;

    bfdd_ram #(
        .WIDTH (4),
        .DEPTH (TABLE_DEPTH)
    ) u_type_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (cmd.lookup),
        .raddr (AW'(p_idx)),
        .rdata (old_type)
    );

    // Extended mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SHORT;
        end
        else if (cmd.commit)
        begin
            mode_reg <= mode_fin;
        end
    end

    // Result word register
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tdata_reg <= {4'd0, mode_fin, (hit_reg ? dtype_reg : DT_NONE),
                            dev_reg, bid_reg, ev};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : bfdd_dp
`default_nettype wire

FILE: rtl/bus_frame_device_discovery.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bus frame device discovery
// Collects received bus bytes into chunks, parses each closed chunk as a
// short or extended frame, classifies the device and tracks known types.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one received byte per word in s_tdata, s_tlast closes the
//   chunk. A chunk also closes when it reaches MAX_CHUNK bytes.
//   Master channel: one result word per closed chunk, none otherwise.
//   cfg_wr_en / cfg_wr_data write own_bus_id (bus id for short frames).
//   A byte that does not close a chunk is taken in the idle state. A closing
//   byte then passes through the type table read and the compare and table
//   update; the result word is registered after that. The type table read
//   is registered, which is why the read and the update are separate steps.
//   After reset the table is swept to zero, all TABLE_DEPTH entries (4096 by
//   default), while s_tready is low; configuration writes are taken.
//   The result sits in an output register: while the receiver stalls, bytes
//   that do not close a chunk are still taken, and the block waits in its
//   update cycle only when a second result is ready before the first is
//   taken.
// ----------------------------------------------------------------------------
module bus_frame_device_discovery #(
    parameter int MAX_CHUNK   = 250,
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // end_of_chunk
    // Results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] event_res, [5:2] bus_id,
                                        // [13:6] device, [17:14] device_type,
                                        // [19:18] extended_mode, [23:20] zero
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);
    import bfdd_pkg::*;

    bfdd_cmd_t cmd;
    bfdd_sts_t sts;

    bfdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfdd_dp #(
        .MAX_CHUNK   (MAX_CHUNK),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .rx_byte     (s_tdata),
        .rx_last     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // No result can come out during the clear pass
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !m_tvalid)
        else $error("result word during table clear");

    // A new result appears only after a commit
    a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result word without commit");

    // A closing word stops intake for the lookup
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && cmd.lookup))
        else $error("intake not stopped after chunk close");

    // Extended mode never reaches the unused code
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:18] != 2'd3))
        else $error("extended mode out of range");

endmodule : bus_frame_device_discovery
`default_nettype wire
